// ----- rtl/lsrs_pkg.sv -----
// Shared constants, codes and stage types of the layered segment request scheduler.
// Used by every module and interface under rtl.
package lsrs_pkg;

	localparam int NUM_LAYERS = 4;
	localparam int LAYER_W    = $clog2(NUM_LAYERS);
	localparam int NCNT_W     = $clog2(NUM_LAYERS + 1);
	localparam int LVL_W      = 16;
	localparam int SEG_BITS   = 16;
	localparam int SEGX_W     = SEG_BITS + 1;
	localparam int GAMMA_W    = 8;
	localparam int ALPHA_W    = 16;
	localparam int OFS_W      = 8;
	localparam int CFG_W      = 16;
	localparam int CIDX_W     = 3;
	localparam int NUM_D      = NUM_LAYERS + 2;
	localparam int D_W        = $clog2(NUM_D);
	localparam int EXTRA_W    = $clog2(((NUM_D - 1) * (2 ** ALPHA_W - 1) + 255) / 256 + 1);
	localparam int TGT_W      = EXTRA_W + 1;
	localparam int THR_W      = TGT_W + 8;

	localparam logic [CIDX_W-1:0] CFG_NUM_LAYERS = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_GAMMA      = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_ALPHA      = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_INC_OFFSET = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_TOTAL_SEGS = 3'd4;

	localparam logic [1:0] PH_STEADY  = 2'd0;
	localparam logic [1:0] PH_GROWING = 2'd1;
	localparam logic [1:0] PH_INCR    = 2'd2;
	localparam logic [1:0] PH_IDLE    = 2'd3;

	typedef struct packed {
		logic [NCNT_W-1:0]                n_layers;
		logic [OFS_W-1:0]                 inc_offset;
		logic [SEG_BITS-1:0]              total_segs;
		logic [NUM_D-1:0][THR_W-1:0]      thr;
	} cfg_t;

	typedef struct packed {
		logic [NUM_LAYERS-1:0][LVL_W-1:0] level;
		logic [NUM_LAYERS-1:0][SEG_BITS-1:0] seg;
		logic [NUM_LAYERS-1:0]            ok;
		logic [LAYER_W-1:0]               top;
		logic                             inc_en;
		logic                             met;
	} s1_t;

	typedef struct packed {
		logic [NUM_LAYERS-1:0]            below_st;
		logic [NUM_LAYERS-1:0]            below_gr;
		logic [NUM_LAYERS-1:0][SEG_BITS-1:0] seg;
		logic [NUM_LAYERS-1:0]            ok;
		logic [LAYER_W-1:0]               top;
		logic                             inc_en;
		logic                             met;
	} s2_t;

endpackage

// ----- rtl/lsrs_req_if.sv -----
// Request channel: valid/ready handshake with per-layer levels and segment numbers.
// Depends on lsrs_pkg.
interface lsrs_req_if;
	import lsrs_pkg::*;

	logic                valid;
	logic                ready;
	logic [LVL_W-1:0]    level_0;
	logic [LVL_W-1:0]    level_1;
	logic [LVL_W-1:0]    level_2;
	logic [LVL_W-1:0]    level_3;
	logic [SEG_BITS-1:0] top_seg_0;
	logic [SEG_BITS-1:0] top_seg_1;
	logic [SEG_BITS-1:0] top_seg_2;
	logic [SEG_BITS-1:0] top_seg_3;
	logic [SEG_BITS-1:0] play_next;
	logic [LAYER_W-1:0]  query_layer;

	modport source (output valid, level_0, level_1, level_2, level_3, top_seg_0, top_seg_1,
		top_seg_2, top_seg_3, play_next, query_layer, input ready);
	modport sink (input valid, level_0, level_1, level_2, level_3, top_seg_0, top_seg_1,
		top_seg_2, top_seg_3, play_next, query_layer, output ready);
endinterface

// ----- rtl/lsrs_res_if.sv -----
// Result channel: valid/ready handshake with the scheduling decision.
// Depends on lsrs_pkg.
interface lsrs_res_if;
	import lsrs_pkg::*;

	logic                valid;
	logic                ready;
	logic                request_valid;
	logic [LAYER_W-1:0]  chosen_layer;
	logic [SEG_BITS-1:0] seg_number;
	logic [1:0]          phase;
	logic                all_downloaded;
	logic                min_level_met;

	modport source (output valid, request_valid, chosen_layer, seg_number, phase,
		all_downloaded, min_level_met, input ready);
	modport sink (input valid, request_valid, chosen_layer, seg_number, phase,
		all_downloaded, min_level_met, output ready);
endinterface

// ----- rtl/layered_segment_request_scheduler.sv -----
// Layered segment request scheduler: top level with config registers and a 3-stage pipeline.
// Throughput: one item per cycle while no held result stalls the pipeline.
// The three pipeline stages advance together; a held result stalls all of them.
// Reset clears all valid bits and loads the default config (1 layer, gamma 8,
// alpha 2.0 s, increase offset 4, total segments 0). Depends on lsrs_pkg,
// lsrs_req_if, lsrs_res_if, lsrs_cfg, lsrs_front, lsrs_cmp and lsrs_pick.
module layered_segment_request_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	lsrs_req_if.sink                    req,
	lsrs_res_if.source                  res,
	input  logic                        cfg_we,
	input  logic [lsrs_pkg::CIDX_W-1:0] cfg_idx,
	input  logic [lsrs_pkg::CFG_W-1:0]  cfg_wdata
);
	import lsrs_pkg::*;

	cfg_t cfg;
	s1_t  d_s1;
	s2_t  d_s2;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic adv;

	assign adv = !v_s3 || res.ready;

	lsrs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lsrs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg),
		.req    (req),
		.v_s1   (v_s1),
		.d_s1   (d_s1)
	);

	lsrs_cmp u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg),
		.v_s1   (v_s1),
		.d_s1   (d_s1),
		.v_s2   (v_s2),
		.d_s2   (d_s2)
	);

	lsrs_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_s2   (v_s2),
		.d_s2   (d_s2),
		.v_s3   (v_s3),
		.res    (res)
	);
endmodule

// ----- rtl/lsrs_cfg.sv -----
// Configuration registers and derived buffer thresholds per layer distance.
// Depends on lsrs_pkg.
module lsrs_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lsrs_pkg::CIDX_W-1:0] cfg_idx,
	input  logic [lsrs_pkg::CFG_W-1:0]  cfg_wdata,
	output lsrs_pkg::cfg_t              cfg
);
	import lsrs_pkg::*;

	logic [2:0]          num_layers_q;
	logic [GAMMA_W-1:0]  gamma_q;
	logic [ALPHA_W-1:0]  alpha_q;
	logic [OFS_W-1:0]    inc_offset_q;
	logic [SEG_BITS-1:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_layers_q <= 3'd1;
			gamma_q      <= GAMMA_W'(8);
			alpha_q      <= ALPHA_W'(512);
			inc_offset_q <= OFS_W'(4);
			total_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_NUM_LAYERS: num_layers_q <= cfg_wdata[2:0];
				CFG_GAMMA:      gamma_q      <= cfg_wdata[GAMMA_W-1:0];
				CFG_ALPHA:      alpha_q      <= cfg_wdata[ALPHA_W-1:0];
				CFG_INC_OFFSET: inc_offset_q <= cfg_wdata[OFS_W-1:0];
				CFG_TOTAL_SEGS: total_q      <= cfg_wdata[SEG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [D_W+ALPHA_W-1:0] prod;
		logic [TGT_W-1:0]       tgt;
		if (num_layers_q == 3'd0)
			cfg.n_layers = NCNT_W'(1);
		else if ({{(32-3){1'b0}}, num_layers_q} > NUM_LAYERS)
			cfg.n_layers = NCNT_W'(NUM_LAYERS);
		else
			cfg.n_layers = NCNT_W'(num_layers_q);
		cfg.inc_offset = inc_offset_q;
		cfg.total_segs = total_q;
		for (int d = 0; d < NUM_D; d++) begin
			prod = D_W'(d) * alpha_q + (D_W+ALPHA_W)'(255);
			tgt = TGT_W'(gamma_q) + TGT_W'(prod >> 8);
			cfg.thr[d] = {tgt, 8'd0};
		end
	end
endmodule

// ----- rtl/lsrs_front.sv -----
// Stage 1: top nonzero layer, next needed segment per layer and the query-layer check.
// Depends on lsrs_pkg and lsrs_req_if.
module lsrs_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  lsrs_pkg::cfg_t cfg,
	lsrs_req_if.sink       req,
	output logic           v_s1,
	output lsrs_pkg::s1_t  d_s1
);
	import lsrs_pkg::*;

	s1_t                                 nxt;
	logic [NUM_LAYERS-1:0][LVL_W-1:0]    lvl;
	logic [NUM_LAYERS-1:0][SEG_BITS-1:0] tseg;

	assign req.ready = adv;
	assign lvl  = {req.level_3, req.level_2, req.level_1, req.level_0};
	assign tseg = {req.top_seg_3, req.top_seg_2, req.top_seg_1, req.top_seg_0};

	always_comb begin
		logic [SEGX_W-1:0]  s;
		logic [LAYER_W-1:0] qm1;
		nxt.level = lvl;
		nxt.top = '0;
		for (int i = 1; i < NUM_LAYERS; i++)
			if (NCNT_W'(i) < cfg.n_layers && lvl[i] != '0)
				nxt.top = LAYER_W'(i);
		nxt.inc_en = (NCNT_W'(nxt.top) + NCNT_W'(1)) < cfg.n_layers;
		for (int i = 0; i < NUM_LAYERS; i++) begin
			if (lvl[i] != '0)
				s = SEGX_W'(tseg[i]) + SEGX_W'(1);
			else if (i == 0)
				s = SEGX_W'(req.play_next);
			else
				s = SEGX_W'(req.play_next) + SEGX_W'(cfg.inc_offset);
			nxt.seg[i] = s[SEG_BITS-1:0];
			nxt.ok[i] = s < SEGX_W'(cfg.total_segs);
		end
		qm1 = req.query_layer - LAYER_W'(1);
		nxt.met = 1'b1;
		if (req.query_layer != '0 && NCNT_W'(req.query_layer) < cfg.n_layers)
			nxt.met = !(THR_W'(lvl[qm1]) < cfg.thr[1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			d_s1 <= nxt;
	end
endmodule

// ----- rtl/lsrs_cmp.sv -----
// Stage 2: buffer level against the steady and growing targets for each layer.
// Depends on lsrs_pkg.
module lsrs_cmp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  lsrs_pkg::cfg_t cfg,
	input  logic           v_s1,
	input  lsrs_pkg::s1_t  d_s1,
	output logic           v_s2,
	output lsrs_pkg::s2_t  d_s2
);
	import lsrs_pkg::*;

	s2_t nxt;

	always_comb begin
		logic [D_W-1:0] d_st;
		logic [D_W-1:0] d_gr;
		nxt.seg    = d_s1.seg;
		nxt.ok     = d_s1.ok;
		nxt.top    = d_s1.top;
		nxt.inc_en = d_s1.inc_en;
		nxt.met    = d_s1.met;
		for (int i = 0; i < NUM_LAYERS; i++) begin
			d_st = D_W'(d_s1.top) - D_W'(i);
			d_gr = d_st + D_W'(2);
			if (LAYER_W'(i) <= d_s1.top) begin
				nxt.below_st[i] = THR_W'(d_s1.level[i]) < cfg.thr[d_st];
				nxt.below_gr[i] = THR_W'(d_s1.level[i]) < cfg.thr[d_gr];
			end else begin
				nxt.below_st[i] = 1'b0;
				nxt.below_gr[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv)
			d_s2 <= nxt;
	end
endmodule

// ----- rtl/lsrs_pick.sv -----
// Stage 3: priority pick over steady, growing and quality-increase candidates.
// Depends on lsrs_pkg and lsrs_res_if; holds the output register.
module lsrs_pick (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          v_s2,
	input  lsrs_pkg::s2_t d_s2,
	output logic          v_s3,
	lsrs_res_if.source    res
);
	import lsrs_pkg::*;

	logic                req_s3;
	logic [LAYER_W-1:0]  layer_s3;
	logic [SEG_BITS-1:0] seg_s3;
	logic [1:0]          phase_s3;
	logic                done_s3;
	logic                met_s3;

	logic                hit;
	logic                past;
	logic [LAYER_W-1:0]  layer;
	logic [SEG_BITS-1:0] seg;
	logic [1:0]          phase;

	always_comb begin
		logic [LAYER_W-1:0] up;
		hit = 1'b0;
		past = 1'b0;
		layer = '0;
		seg = '0;
		phase = PH_IDLE;
		up = d_s2.top + LAYER_W'(1);
		for (int i = 0; i < NUM_LAYERS; i++)
			if (!hit && d_s2.below_st[i]) begin
				if (d_s2.ok[i]) begin
					hit = 1'b1;
					layer = LAYER_W'(i);
					seg = d_s2.seg[i];
					phase = PH_STEADY;
				end else
					past = 1'b1;
			end
		for (int i = 0; i < NUM_LAYERS; i++)
			if (!hit && d_s2.below_gr[i]) begin
				if (d_s2.ok[i]) begin
					hit = 1'b1;
					layer = LAYER_W'(i);
					seg = d_s2.seg[i];
					phase = PH_GROWING;
				end else
					past = 1'b1;
			end
		if (!hit && d_s2.inc_en) begin
			if (d_s2.ok[up]) begin
				hit = 1'b1;
				layer = up;
				seg = d_s2.seg[up];
				phase = PH_INCR;
			end else
				past = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (adv)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s3   <= hit;
			layer_s3 <= layer;
			seg_s3   <= seg;
			phase_s3 <= phase;
			done_s3  <= !hit && past;
			met_s3   <= d_s2.met;
		end
	end

	assign res.valid          = v_s3;
	assign res.request_valid  = req_s3;
	assign res.chosen_layer   = layer_s3;
	assign res.seg_number     = seg_s3;
	assign res.phase          = phase_s3;
	assign res.all_downloaded = done_s3;
	assign res.min_level_met  = met_s3;
endmodule
